// File: design/adpcm_pkg.sv
// ----------------------------------------------------------------------------
// adpcm_pkg
// Shared types and constants of the ADPCM nibble decoder
// ----------------------------------------------------------------------------
package adpcm_pkg;

    // sample and datapath widths
    localparam int SAMPLE_W   = 16;
    localparam int ACC_W      = 23;
    localparam int MAG_W      = SAMPLE_W + 1;
    localparam int MUL_A_W    = 23;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int GAIN_W     = 7;
    localparam int SCALE_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // prediction terms are floored by 2^11
    localparam int PRED_SHIFT = 11;

    // division by 100: floor(x * 41943 / 2^22) is the quotient or one below
    localparam int             DIV_SHIFT = 22;
    localparam int             DIV_W     = 22;
    localparam logic [16:0]    DIV_RECIP = 17'd41943;
    localparam logic [7:0]     DIV_BY    = 8'd100;

    localparam logic [GAIN_W-1:0] GAIN_FULL = 7'd100;

    localparam logic signed [ACC_W-1:0] SAMPLE_MAX = 23'sd32767;
    localparam logic signed [ACC_W-1:0] SAMPLE_MIN = -23'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHIFT_SCALE    = 3'd0,
        CFG_COEF_FIRST     = 3'd1,
        CFG_COEF_SECOND    = 3'd2,
        CFG_START_HIST_ONE = 3'd3,
        CFG_START_HIST_TWO = 3'd4,
        CFG_GAIN_PERCENT   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [SCALE_W-1:0]          shift_scale;
        logic signed [SAMPLE_W-1:0]  coef_first;
        logic signed [SAMPLE_W-1:0]  coef_second;
        logic signed [SAMPLE_W-1:0]  start_hist_one;
        logic signed [SAMPLE_W-1:0]  start_hist_two;
        logic [GAIN_W-1:0]           gain_percent;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_GAIN,
        S_RECIP,
        S_FIX,
        S_CORR,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MUL_PRED1,
        MUL_PRED2,
        MUL_GAIN,
        MUL_RECIP
    } t_mul_sel;

    // sequencer commands to the datapath
    typedef struct packed {
        logic     busy;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_add;
        logic     sum_store;
        logic     recip_step;
        logic     fix_step;
        logic     corr_step;
        logic     out_load;
    } t_ctrl;

    // datapath status to the sequencer
    typedef struct packed {
        logic in_accept;
        logic gain_full;
        logic out_free;
    } t_stat;

endpackage

// File: design/adpcm_cfg.sv
// ----------------------------------------------------------------------------
// adpcm_cfg
// Configuration register file with plain write port
// ----------------------------------------------------------------------------
module adpcm_cfg
    import adpcm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shift_scale    <= '0;
            r_cfg.coef_first     <= '0;
            r_cfg.coef_second    <= '0;
            r_cfg.start_hist_one <= '0;
            r_cfg.start_hist_two <= '0;
            r_cfg.gain_percent   <= GAIN_FULL;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SHIFT_SCALE:    r_cfg.shift_scale    <= i_cfg_data[SCALE_W-1:0];
                CFG_COEF_FIRST:     r_cfg.coef_first     <= i_cfg_data[SAMPLE_W-1:0];
                CFG_COEF_SECOND:    r_cfg.coef_second    <= i_cfg_data[SAMPLE_W-1:0];
                CFG_START_HIST_ONE: r_cfg.start_hist_one <= i_cfg_data[SAMPLE_W-1:0];
                CFG_START_HIST_TWO: r_cfg.start_hist_two <= i_cfg_data[SAMPLE_W-1:0];
                CFG_GAIN_PERCENT:   r_cfg.gain_percent   <= i_cfg_data[GAIN_W-1:0];
                default: ; // unused index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/adpcm_mul.sv
// ----------------------------------------------------------------------------
// adpcm_mul
// Shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module adpcm_mul
    import adpcm_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [PROD_W-1:0]  o_prod
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    always_comb begin
        n_prod = PROD_W'(i_a) * PROD_W'(i_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// File: design/adpcm_ctrl.sv
// ----------------------------------------------------------------------------
// adpcm_ctrl
// Sequencer stepping one sample through the shared multiplier
// ----------------------------------------------------------------------------
module adpcm_ctrl
    import adpcm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_stat.in_accept) n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_SUM;
            S_SUM:   n_state = i_stat.gain_full ? S_OUT : S_GAIN;
            S_GAIN:  n_state = S_RECIP;
            S_RECIP: n_state = S_FIX;
            S_FIX:   n_state = S_CORR;
            S_CORR:  n_state = S_OUT;
            S_OUT:   if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl            = '0;
        o_ctrl.mul_sel    = MUL_PRED1;
        o_ctrl.busy       = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: ;
            S_MUL1: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MUL_PRED1;
            end
            S_MUL2: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MUL_PRED2;
                o_ctrl.acc_add = 1'b1;
            end
            S_SUM:   o_ctrl.sum_store = 1'b1;
            S_GAIN: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MUL_GAIN;
            end
            S_RECIP: begin
                o_ctrl.mul_en     = 1'b1;
                o_ctrl.mul_sel    = MUL_RECIP;
                o_ctrl.recip_step = 1'b1;
            end
            S_FIX:   o_ctrl.fix_step  = 1'b1;
            S_CORR:  o_ctrl.corr_step = 1'b1;
            S_OUT:   o_ctrl.out_load  = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

// File: design/adpcm_nibble_decoder.sv
// ----------------------------------------------------------------------------
// adpcm_nibble_decoder
// 4-bit ADPCM decoder with configurable predictor pair and volume scaling
// ----------------------------------------------------------------------------
// usage
//   input request: i_valid with i_code_byte, i_low_half, i_restart; taken on a
//   clock edge with i_valid high and o_stall low. o_stall is high while a
//   sample is being decoded, so one request is in flight at a time.
//   output request: o_valid with o_pcm_sample; taken when i_stall is low.
//   the result sits in an output register, so the decoder goes back to idle
//   and takes the next request while that result still waits.
//   datapath: one shared 23x17 multiplier does both prediction products, the
//   volume product and the divide by 100 (reciprocal multiply plus one
//   correction step). at full volume the sequencer steps MUL1, MUL2, SUM,
//   OUT; below volume 100 it runs GAIN, RECIP, FIX, CORR between SUM and
//   OUT. o_valid rises and o_stall drops in the same cycle, so a new request
//   is taken only once the last result is in the output register. a stalled
//   output holds the sequencer in its last step.
//   configuration: write i_cfg_we / i_cfg_index / i_cfg_data while idle.
//   reset: history, sequencer and output valid clear; registers return to
//   their defaults (volume 100, everything else zero).
// ----------------------------------------------------------------------------
module adpcm_nibble_decoder
    import adpcm_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_code_byte,
    input  logic                        i_low_half,
    input  logic                        i_restart,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [SAMPLE_W-1:0]  o_pcm_sample
);

    t_cfg  w_cfg;
    t_ctrl w_ctrl;
    t_stat w_stat;

    logic w_in_accept;
    logic w_out_free;

    // history and working registers
    logic signed [SAMPLE_W-1:0] r_hist_one;
    logic signed [SAMPLE_W-1:0] r_hist_two;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_res;
    logic                       r_neg;
    logic [MAG_W-1:0]           r_mag;
    logic [DIV_W-1:0]           r_dividend;
    logic [SAMPLE_W-1:0]        r_quot;
    logic [7:0]                 r_rem;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data;

    // multiplier operands and product
    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic signed [MUL_B_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0]   w_prod;

    logic [3:0]                 w_code;
    logic signed [ACC_W-1:0]    w_delta;
    logic signed [ACC_W-1:0]    w_pred_term;
    logic signed [ACC_W-1:0]    w_sum;
    logic signed [SAMPLE_W-1:0] w_sat;
    logic [MAG_W-1:0]           w_sat_ext;
    logic [MAG_W-1:0]           w_abs;
    logic [SAMPLE_W-1:0]        w_q0;
    logic [DIV_W-1:0]           w_q0_x100;
    logic [DIV_W-1:0]           w_rem;
    logic [SAMPLE_W-1:0]        w_quot;

    adpcm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    adpcm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    adpcm_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_ctrl.mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // handshakes
    assign o_stall     = w_ctrl.busy;
    assign w_in_accept = i_valid && !w_ctrl.busy;
    assign w_out_free  = !r_out_valid || !i_stall;

    assign w_stat.in_accept = w_in_accept;
    assign w_stat.gain_full = (w_cfg.gain_percent >= GAIN_FULL);
    assign w_stat.out_free  = w_out_free;

    // nibble select, sign extend, scale shift
    assign w_code  = i_low_half ? i_code_byte[3:0] : i_code_byte[7:4];
    assign w_delta = $signed({{(ACC_W-4){w_code[3]}}, w_code}) <<< w_cfg.shift_scale;

    // floor(product / 2^11), the product of a coefficient and a history value
    assign w_pred_term = w_prod[PRED_SHIFT+ACC_W-1:PRED_SHIFT];

    // final sum and clamp to 16 bits
    assign w_sum = r_acc + w_pred_term;
    always_comb begin
        if (w_sum > SAMPLE_MAX) begin
            w_sat = SAMPLE_MAX[SAMPLE_W-1:0];
        end else if (w_sum < SAMPLE_MIN) begin
            w_sat = SAMPLE_MIN[SAMPLE_W-1:0];
        end else begin
            w_sat = w_sum[SAMPLE_W-1:0];
        end
    end

    // magnitude so that the divide truncates toward zero
    assign w_sat_ext = {w_sat[SAMPLE_W-1], w_sat};
    assign w_abs     = w_sat[SAMPLE_W-1] ? (~w_sat_ext + MAG_W'(1)) : w_sat_ext;

    // multiplier operand select
    always_comb begin
        unique case (w_ctrl.mul_sel)
            MUL_PRED1: begin
                w_mul_a = MUL_A_W'(w_cfg.coef_first);
                w_mul_b = MUL_B_W'(r_hist_one);
            end
            MUL_PRED2: begin
                w_mul_a = MUL_A_W'(w_cfg.coef_second);
                w_mul_b = MUL_B_W'(r_hist_two);
            end
            MUL_GAIN: begin
                w_mul_a = $signed({{(MUL_A_W-MAG_W){1'b0}}, r_mag});
                w_mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, w_cfg.gain_percent});
            end
            MUL_RECIP: begin
                w_mul_a = $signed({{(MUL_A_W-DIV_W){1'b0}}, w_prod[DIV_W-1:0]});
                w_mul_b = $signed(DIV_RECIP);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // quotient estimate and its remainder: q0*100 as shift-and-add
    assign w_q0      = w_prod[DIV_SHIFT+SAMPLE_W-1:DIV_SHIFT];
    assign w_q0_x100 = DIV_W'({w_q0, 6'b0}) + DIV_W'({w_q0, 5'b0}) + DIV_W'({w_q0, 2'b0});
    assign w_rem     = r_dividend - w_q0_x100;

    // estimate is exact or one low
    assign w_quot = r_quot + SAMPLE_W'(r_rem >= DIV_BY);

    // history: restart loads the start values at accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_one <= '0;
            r_hist_two <= '0;
        end else if (w_in_accept && i_restart) begin
            r_hist_one <= w_cfg.start_hist_one;
            r_hist_two <= w_cfg.start_hist_two;
        end else if (w_ctrl.sum_store) begin
            r_hist_two <= r_hist_one;
            r_hist_one <= w_sat;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_acc <= w_delta;
        end else if (w_ctrl.acc_add) begin
            r_acc <= w_sum;
        end
        if (w_ctrl.sum_store) begin
            r_res <= w_sat;
            r_neg <= w_sat[SAMPLE_W-1];
            r_mag <= w_abs;
        end
        if (w_ctrl.recip_step) begin
            r_dividend <= w_prod[DIV_W-1:0];
        end
        if (w_ctrl.fix_step) begin
            r_quot <= w_q0;
            r_rem  <= w_rem[7:0];
        end
        if (w_ctrl.corr_step) begin
            r_res <= r_neg ? $signed(-w_quot) : $signed(w_quot);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.out_load) begin
            r_out_data <= r_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pcm_sample = r_out_data;

endmodule
